FILE: src/svh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package svh_pkg;

  localparam int CoordW  = 24;
  localparam int ValueW  = 16;
  localparam int FracW   = 8;
  localparam int BinW    = 25;  // floor(pos / 256) of a 33-bit signed position
  localparam int CountW  = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;
  localparam int DigW    = 8;   // widest bin digit (256 bins)

  localparam logic [1:0] OP_VOTE     = 2'd0;
  localparam logic [1:0] OP_FIND_MAX = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;  // accepted and dropped

  localparam logic [CfgIdxW-1:0] REG_MIN_X       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_Y       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE_INV   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_INV   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_X_INV       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_Y_INV       = 3'd5;

  localparam logic [CfgW-1:0] INV_RESET = 24'h010000;

  // axis order: scale, angle, x, y
  typedef struct packed {
    logic [1:0]                  op;
    logic [3:0][BinW-1:0]        bin;
    logic [3:0][FracW-1:0]       frac;
    logic [ValueW-1:0]           value;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic cmd_pop;
  } back_ctl_t;

  typedef enum logic [1:0] {F_IDLE, F_NORM, F_PUSH} front_state_e;

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_VOTE, B_CLEAR, B_SCAN, B_SCAN_END, B_RESULT
  } back_state_e;

endpackage
`default_nettype wire

FILE: src/svh_front.sv
`timescale 1ns / 1ps
`default_nettype none
module svh_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [svh_pkg::CoordW-1:0]   scale_coord_i,
  input  wire logic [svh_pkg::CoordW-1:0]   angle_coord_i,
  input  wire logic [svh_pkg::CoordW-1:0]   x_coord_i,
  input  wire logic [svh_pkg::CoordW-1:0]   y_coord_i,
  input  wire logic [svh_pkg::ValueW-1:0]   vote_value_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [svh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [svh_pkg::CfgW-1:0]     cfg_data_i,
  input  wire svh_pkg::back_ctl_t           ctl_i,
  output svh_pkg::cmd_t                     cmd_o,
  output logic                              cmd_valid_o
);

  localparam int PosW  = svh_pkg::BinW + svh_pkg::FracW;
  localparam int DiffW = svh_pkg::CoordW + 1;
  localparam int ProdW = DiffW + svh_pkg::CfgW + 1;

  logic [svh_pkg::CfgW-1:0] min_x_q, min_y_q, s_inv_q, a_inv_q, x_inv_q, y_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      s_inv_q <= svh_pkg::INV_RESET;
      a_inv_q <= svh_pkg::INV_RESET;
      x_inv_q <= svh_pkg::INV_RESET;
      y_inv_q <= svh_pkg::INV_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svh_pkg::REG_MIN_X:     min_x_q <= cfg_data_i;
        svh_pkg::REG_MIN_Y:     min_y_q <= cfg_data_i;
        svh_pkg::REG_SCALE_INV: s_inv_q <= cfg_data_i;
        svh_pkg::REG_ANGLE_INV: a_inv_q <= cfg_data_i;
        svh_pkg::REG_X_INV:     x_inv_q <= cfg_data_i;
        svh_pkg::REG_Y_INV:     y_inv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  svh_pkg::front_state_e state_q, state_d;
  logic [1:0] ax_q, ax_d;
  logic [1:0] op_q;
  logic [3:0][svh_pkg::CoordW-1:0] coord_q;
  logic [svh_pkg::ValueW-1:0] value_q;
  logic [3:0][svh_pkg::BinW-1:0]  bin_q;
  logic [3:0][svh_pkg::FracW-1:0] frac_q;

  // command queue, two entries
  svh_pkg::cmd_t fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       fifo_full, fifo_wr;

  assign fifo_full   = cnt_q[1];
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = fifo_q[rp_q];

  logic accept;
  assign full   = (state_q != svh_pkg::F_IDLE) || ctl_i.init_busy;
  assign accept = push && !full;

  // one axis per cycle through a single multiplier
  logic [svh_pkg::CoordW-1:0] coord_sel, origin_sel;
  logic [svh_pkg::CfgW-1:0]   inv_sel;
  logic signed [DiffW-1:0]    diff;
  logic signed [ProdW-1:0]    prod;
  logic [PosW-1:0]            pos;

  always_comb begin
    coord_sel  = coord_q[ax_q];
    origin_sel = '0;
    inv_sel    = s_inv_q;
    case (ax_q)
      2'd0: inv_sel = s_inv_q;
      2'd1: inv_sel = a_inv_q;
      2'd2: begin
        inv_sel    = x_inv_q;
        origin_sel = min_x_q;
      end
      default: begin
        inv_sel    = y_inv_q;
        origin_sel = min_y_q;
      end
    endcase
    diff = $signed({coord_sel[svh_pkg::CoordW-1], coord_sel})
         - $signed({origin_sel[svh_pkg::CoordW-1], origin_sel});
    prod = ProdW'(diff) * $signed({1'b0, inv_sel});
    pos  = prod[PosW+15:16];  // arithmetic floor of prod / 2^16
  end

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    fifo_wr = 1'b0;
    unique case (state_q)
      svh_pkg::F_IDLE: begin
        if (accept) begin
          ax_d = 2'd0;
          unique case (opcode_i) inside
            svh_pkg::OP_VOTE:                       state_d = svh_pkg::F_NORM;
            svh_pkg::OP_FIND_MAX, svh_pkg::OP_CLEAR: state_d = svh_pkg::F_PUSH;
            default:                                state_d = svh_pkg::F_IDLE;
          endcase
        end
      end
      svh_pkg::F_NORM: begin
        ax_d = ax_q + 2'd1;
        if (ax_q == 2'd3) state_d = svh_pkg::F_PUSH;
      end
      svh_pkg::F_PUSH: begin
        if (!fifo_full) begin
          fifo_wr = 1'b1;
          state_d = svh_pkg::F_IDLE;
        end
      end
      default: state_d = svh_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svh_pkg::F_IDLE;
      ax_q    <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      if (fifo_wr) wp_q <= ~wp_q;
      if (ctl_i.cmd_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(fifo_wr) - 2'(ctl_i.cmd_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= opcode_i;
      coord_q[0] <= scale_coord_i;
      coord_q[1] <= angle_coord_i;
      coord_q[2] <= x_coord_i;
      coord_q[3] <= y_coord_i;
      value_q    <= vote_value_i;
    end
    if (state_q == svh_pkg::F_NORM) begin
      bin_q[ax_q]  <= pos[PosW-1:svh_pkg::FracW];
      frac_q[ax_q] <= pos[svh_pkg::FracW-1:0];
    end
    if (fifo_wr) begin
      fifo_q[wp_q].op    <= op_q;
      fifo_q[wp_q].bin   <= bin_q;
      fifo_q[wp_q].frac  <= frac_q;
      fifo_q[wp_q].value <= value_q;
    end
  end

endmodule
`default_nettype wire

FILE: src/svh_back.sv
`timescale 1ns / 1ps
`default_nettype none
module svh_back #(
  parameter int SCALE_BINS = 8,
  parameter int ANGLE_BINS = 16,
  parameter int X_BINS     = 16,
  parameter int Y_BINS     = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire svh_pkg::cmd_t                cmd_i,
  input  wire logic                         cmd_valid_i,
  output svh_pkg::back_ctl_t                ctl_o,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [3:0][svh_pkg::DigW-1:0]     best_dig_o,
  output logic [svh_pkg::CountW-1:0]        best_count_o
);

  localparam int Cells = SCALE_BINS * ANGLE_BINS * X_BINS * Y_BINS;
  localparam int AW    = $clog2(Cells);
  localparam int StrS  = ANGLE_BINS * X_BINS * Y_BINS;
  localparam int StrA  = X_BINS * Y_BINS;
  localparam int StrX  = Y_BINS;
  localparam int BW    = svh_pkg::BinW + 1;
  localparam int CW    = svh_pkg::CountW;
  localparam int AmtW  = svh_pkg::ValueW + 11 - 13;
  localparam int Lim [4] = '{SCALE_BINS, ANGLE_BINS, X_BINS, Y_BINS};

  logic [CW-1:0] mem [Cells];
  logic [CW-1:0] rd_data_q;
  logic [AW-1:0] rd_addr, mem_wa;
  logic [CW-1:0] mem_wd;
  logic          mem_we;

  svh_pkg::back_state_e state_q, state_d;
  svh_pkg::cmd_t cmd_q;
  logic [3:0]    corner_q;
  logic [AW-1:0] cnt_q;
  logic [3:0][svh_pkg::DigW-1:0] dig_q, dig_d;
  logic          dig_carry;
  logic          cmd_pop, cnt_last;

  // update pipeline: stage 1 holds the issued corner while its read lands
  logic          s1_vote_q, s1_in_q, s1_scan_q;
  logic [AW-1:0] s1_addr_q;
  logic [AmtW-1:0] s1_amt_q;
  logic [3:0][svh_pkg::DigW-1:0] s1_dig_q;

  logic [CW-1:0] best_val_q;
  logic [3:0][svh_pkg::DigW-1:0] best_dig_q;
  logic          out_valid_q, out_load;

  assign cnt_last = cnt_q == AW'(Cells - 1);

  // corner of the current vote
  logic signed [BW-1:0]           b [4];
  logic [3:0][svh_pkg::DigW-1:0]  cdig;
  logic [3:0]                     in_ax;
  logic [8:0]                     w [4];
  logic [10:0]                    wsum;
  logic [svh_pkg::ValueW+10:0]    amt_full;
  logic [AW-1:0]                  corner_addr;

  always_comb begin
    wsum = '0;
    for (int k = 0; k < 4; k++) begin
      b[k]     = $signed({cmd_q.bin[k][svh_pkg::BinW-1], cmd_q.bin[k]})
               + $signed(BW'(corner_q[3-k]));
      in_ax[k] = !b[k][BW-1] && (b[k] < $signed(BW'(Lim[k])));
      cdig[k]  = b[k][svh_pkg::DigW-1:0];
      w[k]     = corner_q[3-k] ? {1'b0, cmd_q.frac[k]} : 9'd256 - {1'b0, cmd_q.frac[k]};
      wsum     = wsum + 11'(w[k]);
    end
    amt_full    = cmd_q.value * wsum;
    corner_addr = AW'(AW'(cdig[0]) * AW'(StrS)) + AW'(AW'(cdig[1]) * AW'(StrA))
                + AW'(AW'(cdig[2]) * AW'(StrX)) + AW'(cdig[3]);
  end

  // mixed-radix digits of the next scan address, y fastest
  always_comb begin
    dig_d     = dig_q;
    dig_carry = 1'b1;
    for (int k = 3; k >= 0; k--) begin
      if (dig_carry) begin
        if (dig_q[k] == svh_pkg::DigW'(Lim[k] - 1)) begin
          dig_d[k] = '0;
        end else begin
          dig_d[k]  = dig_q[k] + svh_pkg::DigW'(1);
          dig_carry = 1'b0;
        end
      end
    end
  end

  logic [CW:0] sat_sum;
  assign sat_sum = {1'b0, rd_data_q} + (CW+1)'(s1_amt_q);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = s1_addr_q;
    mem_wd = sat_sum[CW] ? '1 : sat_sum[CW-1:0];
    if (state_q == svh_pkg::B_INIT || state_q == svh_pkg::B_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = cnt_q;
      mem_wd = '0;
    end else if (s1_vote_q && s1_in_q) begin
      mem_we = 1'b1;
    end
    rd_addr = (state_q == svh_pkg::B_VOTE) ? corner_addr : cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d  = state_q;
    cmd_pop  = 1'b0;
    out_load = 1'b0;
    unique case (state_q) inside
      svh_pkg::B_INIT, svh_pkg::B_CLEAR: begin
        if (cnt_last) state_d = svh_pkg::B_IDLE;
      end
      svh_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop = 1'b1;
          unique case (cmd_i.op)
            svh_pkg::OP_VOTE:     state_d = svh_pkg::B_VOTE;
            svh_pkg::OP_FIND_MAX: state_d = svh_pkg::B_SCAN;
            svh_pkg::OP_CLEAR:    state_d = svh_pkg::B_CLEAR;
            default:              state_d = svh_pkg::B_IDLE;
          endcase
        end
      end
      svh_pkg::B_VOTE: begin
        if (corner_q == 4'd15) state_d = svh_pkg::B_IDLE;
      end
      svh_pkg::B_SCAN: begin
        if (cnt_last) state_d = svh_pkg::B_SCAN_END;
      end
      svh_pkg::B_SCAN_END: state_d = svh_pkg::B_RESULT;
      svh_pkg::B_RESULT: begin
        if (!out_valid_q) begin
          out_load = 1'b1;
          state_d  = svh_pkg::B_IDLE;
        end
      end
      default: state_d = svh_pkg::B_IDLE;
    endcase
  end

  assign ctl_o.init_busy = state_q == svh_pkg::B_INIT;
  assign ctl_o.cmd_pop   = cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svh_pkg::B_INIT;
      cnt_q       <= '0;
      corner_q    <= '0;
      dig_q       <= '0;
      s1_vote_q   <= 1'b0;
      s1_scan_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_vote_q <= state_q == svh_pkg::B_VOTE;
      s1_scan_q <= state_q == svh_pkg::B_SCAN;
      if (cmd_pop) begin
        cnt_q    <= '0;
        corner_q <= '0;
        dig_q    <= '0;
      end else begin
        if (state_q == svh_pkg::B_VOTE) corner_q <= corner_q + 4'd1;
        if (state_q == svh_pkg::B_INIT || state_q == svh_pkg::B_CLEAR ||
            state_q == svh_pkg::B_SCAN) begin
          cnt_q <= cnt_last ? '0 : cnt_q + AW'(1);
        end
        // digits follow the scan address
        if (state_q == svh_pkg::B_SCAN) dig_q <= dig_d;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (pop && out_valid_q) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == svh_pkg::B_IDLE && cmd_pop) cmd_q <= cmd_i;
    s1_addr_q <= corner_addr;
    s1_in_q   <= &in_ax;
    s1_amt_q  <= amt_full[svh_pkg::ValueW+10:13];
    s1_dig_q  <= dig_q;
    if (cmd_pop) begin
      best_val_q <= '0;
      best_dig_q <= '0;
    end else if (s1_scan_q && rd_data_q > best_val_q) begin
      best_val_q <= rd_data_q;
      best_dig_q <= s1_dig_q;
    end
    if (out_load) begin
      best_dig_o   <= best_dig_q;
      best_count_o <= best_val_q;
    end
  end

  assign empty = !out_valid_q;

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svh_pkg::B_SCAN || state_q == svh_pkg::B_SCAN_END) |-> !mem_we)
    else $error("store written during max scan");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (state_q == svh_pkg::B_IDLE && cmd_valid_i))
    else $error("command popped outside idle");
  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svh_pkg::B_RESULT && !out_valid_q) |=> out_valid_q)
    else $error("max result not loaded");
  a_vote_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svh_pkg::B_VOTE && corner_q == 4'd15) |=> state_q == svh_pkg::B_IDLE)
    else $error("vote did not end after sixteen corners");

endmodule
`default_nettype wire

FILE: src/soft_vote_4d_hough_accumulator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Dense 4-D soft-vote accumulator (scale, angle, x, y bins; y fastest) held in one
// single-port-write memory of 32-bit saturating counters. A vote is normalized axis
// by axis in the front (one shared multiplier), then applied by read-modify-write
// in the back to sixteen neighbor cells, one neighbor cell per cycle. Find-max scans
// every cell, one per cycle, and returns one result beat.
// Clear sweeps the store, one cell per cycle. After reset the store is cleared
// by the same sweep (over every cell, 32768 at default sizes) during which full
// stays high; configuration writes are taken at any time but belong in idle periods.
module soft_vote_4d_hough_accumulator_unit #(
  parameter int SCALE_BINS = 8,
  parameter int ANGLE_BINS = 16,
  parameter int X_BINS     = 16,
  parameter int Y_BINS     = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input queue side
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [svh_pkg::CoordW-1:0]   scale_coord_i,
  input  wire logic [svh_pkg::CoordW-1:0]   angle_coord_i,
  input  wire logic [svh_pkg::CoordW-1:0]   x_coord_i,
  input  wire logic [svh_pkg::CoordW-1:0]   y_coord_i,
  input  wire logic [svh_pkg::ValueW-1:0]   vote_value_i,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [svh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [svh_pkg::CfgW-1:0]     cfg_data_i,
  // result queue side
  output logic                              empty,
  input  wire logic                         pop,
  output logic [2:0]                        best_scale_bin_o,
  output logic [3:0]                        best_angle_bin_o,
  output logic [3:0]                        best_x_bin_o,
  output logic [3:0]                        best_y_bin_o,
  output logic [svh_pkg::CountW-1:0]        best_count_o
);

  svh_pkg::cmd_t     cmd;
  logic              cmd_valid;
  svh_pkg::back_ctl_t ctl;
  logic [3:0][svh_pkg::DigW-1:0] best_dig;

  // front: accepts beats, normalizes votes, queues commands
  svh_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .opcode_i, .scale_coord_i, .angle_coord_i, .x_coord_i, .y_coord_i, .vote_value_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ctl_i       (ctl),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  // back: owns the store, runs votes, clears and the max scan
  svh_back #(
    .SCALE_BINS(SCALE_BINS), .ANGLE_BINS(ANGLE_BINS), .X_BINS(X_BINS), .Y_BINS(Y_BINS)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .cmd_valid_i  (cmd_valid),
    .ctl_o        (ctl),
    .empty, .pop,
    .best_dig_o   (best_dig),
    .best_count_o
  );

  // bins wider than the result fields are masked
  assign best_scale_bin_o = best_dig[0][2:0];
  assign best_angle_bin_o = best_dig[1][3:0];
  assign best_x_bin_o     = best_dig[2][3:0];
  assign best_y_bin_o     = best_dig[3][3:0];

endmodule
`default_nettype wire
